/* sv/oled_frame_refresh_sequencer_defines.svh */
// Assertion macros used by the refresh sequencer back end
`ifndef OLED_FRAME_REFRESH_SEQUENCER_DEFINES_SVH
`define OLED_FRAME_REFRESH_SEQUENCER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define OFRS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ofrs: same-cycle check failed");

// next-cycle implication, clocked on clk, off during reset
`define OFRS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ofrs: next-cycle check failed");

`endif

/* sv/ofrs_pkg.sv */
// Shared types and constants for the OLED frame refresh sequencer
package ofrs_pkg;

    localparam int PANEL_WIDTH   = 128;
    localparam int STORE_BYTES   = 1024;

    localparam int BYTE_W        = 8;
    localparam int REQ_W         = 2;
    localparam int STORE_INDEX_W = 10;
    localparam int IDX_CMP_W     = STORE_INDEX_W + 1;
    localparam int RAM_AW        = $clog2(STORE_BYTES);
    localparam int PAGE_W        = 3;
    localparam int COL_W         = $clog2(PANEL_WIDTH);
    localparam int LIN_A         = PAGE_W + COL_W;
    localparam int LIN_B         = $clog2(STORE_BYTES + 1);
    localparam int LIN_W         = (LIN_A > LIN_B) ? LIN_A : LIN_B;
    localparam int BCNT_W        = $clog2(PANEL_WIDTH + 1);

    localparam int QDEPTH        = 2;
    localparam int QPTR_W        = $clog2(QDEPTH);
    localparam int QCNT_W        = $clog2(QDEPTH + 1);

    localparam int PADDR_W       = 4;
    localparam int PDATA_W       = 32;
    localparam int REG_IDX_W     = 2;

    localparam logic [REG_IDX_W-1:0] REG_BUS_KIND   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_PANEL_KIND = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_TALL_PANEL = 2'd2;

    localparam int WIN_LEN  = 6;
    localparam int PCMD_LEN = 3;

    localparam logic [BYTE_W-1:0] CTRL_CMD        = 8'h00;
    localparam logic [BYTE_W-1:0] CTRL_DATA       = 8'h40;
    localparam logic [BYTE_W-1:0] CMD_COL_WINDOW  = 8'h21;
    localparam logic [BYTE_W-1:0] CMD_PAGE_WINDOW = 8'h22;
    localparam logic [BYTE_W-1:0] CMD_PAGE_BASE   = 8'hB0;
    localparam logic [BYTE_W-1:0] CMD_COL_LOW     = 8'h02;
    localparam logic [BYTE_W-1:0] CMD_COL_HIGH    = 8'h10;
    localparam logic [BYTE_W-1:0] FILL_BYTE       = 8'h00;

    typedef enum logic [REQ_W-1:0] {
        OP_WRITE = 2'd0,
        OP_CLEAR = 2'd1,
        OP_START = 2'd2,
        OP_PULL  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        PH_WINDOW,
        PH_PAGECMD,
        PH_DATA
    } phase_t;

    typedef enum logic [1:0] {
        BS_INIT,
        BS_RUN,
        BS_LOAD,
        BS_SWEEP
    } back_state_t;

    typedef struct packed {
        logic bus_kind;
        logic panel_kind;
        logic tall_panel;
    } cfg_t;

    typedef struct packed {
        op_t                 op;
        logic [RAM_AW-1:0]   addr;
        logic [BYTE_W-1:0]   data;
    } q_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              cmd;
        logic              start;
        logic              last;
    } out_word_t;

    typedef struct packed {
        out_word_t word;
        logic      from_ram;
    } pend_t;

endpackage

/* sv/ofrs_ram.sv */
// Generic simple dual-port RAM with registered read
module ofrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/ofrs_front.sv */
// Front end: accepts request words, classifies them and pushes them into the queue
module ofrs_front (
    input  logic                                 req_valid,
    output logic                                 req_stall,
    input  logic [ofrs_pkg::REQ_W-1:0]           req_type,
    input  logic [ofrs_pkg::STORE_INDEX_W-1:0]   store_index,
    input  logic [ofrs_pkg::BYTE_W-1:0]          store_data,
    input  logic                                 q_full,
    input  logic                                 init_busy,
    output logic                                 push,
    output ofrs_pkg::q_item_t                    item
);

    ofrs_pkg::op_t op;
    logic          accept;
    logic          in_range;
    logic          keep;

    assign op        = ofrs_pkg::op_t'(req_type);
    assign req_stall = q_full || init_busy;
    assign accept    = req_valid && !req_stall;

    assign in_range  = ofrs_pkg::IDX_CMP_W'(store_index)
                       < ofrs_pkg::IDX_CMP_W'(ofrs_pkg::STORE_BYTES);

    // out-of-range writes are dropped here
    assign keep      = (op != ofrs_pkg::OP_WRITE) || in_range;
    assign push      = accept && keep;

    assign item.op   = op;
    assign item.addr = store_index[ofrs_pkg::RAM_AW-1:0];
    assign item.data = store_data;

endmodule

/* sv/ofrs_queue.sv */
// Short FIFO between front end and sequencer back end
module ofrs_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ofrs_pkg::q_item_t item_in,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output ofrs_pkg::q_item_t item_out
);

    ofrs_pkg::q_item_t               slot_reg [ofrs_pkg::QDEPTH];
    logic [ofrs_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [ofrs_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [ofrs_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [ofrs_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [ofrs_pkg::QCNT_W-1:0]     count_reg;
    logic [ofrs_pkg::QCNT_W-1:0]     count_next;
    logic                            do_push;
    logic                            do_pop;

    assign full     = count_reg == ofrs_pkg::QCNT_W'(ofrs_pkg::QDEPTH);
    assign valid    = count_reg != '0;
    assign item_out = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == ofrs_pkg::QPTR_W'(ofrs_pkg::QDEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == ofrs_pkg::QPTR_W'(ofrs_pkg::QDEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

/* sv/ofrs_back.sv */
// Back end: frame store, clear sweeps and refresh byte sequencer
`include "oled_frame_refresh_sequencer_defines.svh"

module ofrs_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ofrs_pkg::cfg_t                cfg,
    input  logic                          q_valid,
    input  ofrs_pkg::q_item_t             q_item,
    output logic                          q_pop,
    output logic                          init_busy,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [ofrs_pkg::BYTE_W-1:0]   out_byte,
    output logic                          is_command,
    output logic                          txn_start,
    output logic                          last_byte
);

    localparam int KW = ofrs_pkg::BCNT_W + 1;

    ofrs_pkg::back_state_t               state_reg;
    ofrs_pkg::back_state_t               state_next;
    logic                                active_reg;
    logic                                active_next;
    ofrs_pkg::phase_t                    phase_reg;
    ofrs_pkg::phase_t                    phase_next;
    logic [ofrs_pkg::PAGE_W-1:0]         page_reg;
    logic [ofrs_pkg::PAGE_W-1:0]         page_next;
    logic [ofrs_pkg::BCNT_W-1:0]         bcnt_reg;
    logic [ofrs_pkg::BCNT_W-1:0]         bcnt_next;
    logic [ofrs_pkg::RAM_AW-1:0]         sweep_reg;
    logic [ofrs_pkg::RAM_AW-1:0]         sweep_next;
    ofrs_pkg::pend_t                     pend_reg;
    ofrs_pkg::pend_t                     pend_next;
    ofrs_pkg::out_word_t                 out_word_reg;
    ofrs_pkg::out_word_t                 out_word_next;
    logic                                out_valid_reg;
    logic                                out_valid_next;

    logic                                ram_we;
    logic [ofrs_pkg::RAM_AW-1:0]         ram_waddr;
    logic [ofrs_pkg::BYTE_W-1:0]         ram_wdata;
    logic [ofrs_pkg::RAM_AW-1:0]         ram_raddr;
    logic [ofrs_pkg::BYTE_W-1:0]         ram_rdata;

    logic                                sweep_done;
    logic                                out_free;

    // sequencer step for the current pull
    logic                                prefix;
    logic                                is_pre;
    logic [KW-1:0]                       kp1;
    logic [ofrs_pkg::BCNT_W-1:0]         idx;
    logic [ofrs_pkg::PAGE_W-1:0]         pages_m1;
    logic                                page_last;
    logic [ofrs_pkg::LIN_W-1:0]          lin;
    logic                                in_range;
    ofrs_pkg::pend_t                     seq_word;
    logic                                seq_active;
    ofrs_pkg::phase_t                    seq_phase;
    logic [ofrs_pkg::PAGE_W-1:0]         seq_page;
    logic [ofrs_pkg::BCNT_W-1:0]         seq_bcnt;

    ofrs_ram #(
        .WIDTH (ofrs_pkg::BYTE_W),
        .DEPTH (ofrs_pkg::STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign sweep_done = sweep_reg == ofrs_pkg::RAM_AW'(ofrs_pkg::STORE_BYTES - 1);
    assign out_free   = !out_valid_reg || !rsp_stall;
    assign init_busy  = state_reg == ofrs_pkg::BS_INIT;

    assign prefix    = !cfg.bus_kind;
    assign is_pre    = prefix && (bcnt_reg == '0);
    assign kp1       = KW'(bcnt_reg) + KW'(1);
    assign idx       = bcnt_reg - ofrs_pkg::BCNT_W'(prefix);
    assign pages_m1  = cfg.tall_panel ? ofrs_pkg::PAGE_W'(7) : ofrs_pkg::PAGE_W'(3);
    assign page_last = ({1'b0, page_reg} + 4'd1) >= (cfg.tall_panel ? 4'd8 : 4'd4);
    assign lin       = ofrs_pkg::LIN_W'(page_reg) * ofrs_pkg::LIN_W'(ofrs_pkg::PANEL_WIDTH)
                       + ofrs_pkg::LIN_W'(idx);
    assign in_range  = lin < ofrs_pkg::LIN_W'(ofrs_pkg::STORE_BYTES);
    assign ram_raddr = lin[ofrs_pkg::RAM_AW-1:0];

    always_comb
    begin
        seq_word.word.data  = ofrs_pkg::FILL_BYTE;
        seq_word.word.cmd   = 1'b1;
        seq_word.word.start = bcnt_reg == '0;
        seq_word.word.last  = 1'b0;
        seq_word.from_ram   = 1'b0;
        seq_active          = active_reg;
        seq_phase           = phase_reg;
        seq_page            = page_reg;
        seq_bcnt            = kp1[ofrs_pkg::BCNT_W-1:0];
        unique case (phase_reg)
            ofrs_pkg::PH_WINDOW:
            begin
                if (is_pre)
                begin
                    seq_word.word.data = ofrs_pkg::CTRL_CMD;
                end
                else if (idx == ofrs_pkg::BCNT_W'(0))
                begin
                    seq_word.word.data = ofrs_pkg::CMD_COL_WINDOW;
                end
                else if (idx == ofrs_pkg::BCNT_W'(2))
                begin
                    seq_word.word.data = ofrs_pkg::BYTE_W'(ofrs_pkg::PANEL_WIDTH - 1);
                end
                else if (idx == ofrs_pkg::BCNT_W'(3))
                begin
                    seq_word.word.data = ofrs_pkg::CMD_PAGE_WINDOW;
                end
                else if (idx == ofrs_pkg::BCNT_W'(5))
                begin
                    seq_word.word.data = ofrs_pkg::BYTE_W'(pages_m1);
                end
                if (kp1 >= KW'(ofrs_pkg::WIN_LEN) + KW'(prefix))
                begin
                    seq_phase = ofrs_pkg::PH_DATA;
                    seq_page  = '0;
                    seq_bcnt  = '0;
                end
            end
            ofrs_pkg::PH_PAGECMD:
            begin
                if (is_pre)
                begin
                    seq_word.word.data = ofrs_pkg::CTRL_CMD;
                end
                else if (idx == ofrs_pkg::BCNT_W'(0))
                begin
                    seq_word.word.data = ofrs_pkg::CMD_PAGE_BASE
                                         + ofrs_pkg::BYTE_W'(page_reg);
                end
                else if (idx == ofrs_pkg::BCNT_W'(1))
                begin
                    seq_word.word.data = ofrs_pkg::CMD_COL_LOW;
                end
                else if (idx == ofrs_pkg::BCNT_W'(2))
                begin
                    seq_word.word.data = ofrs_pkg::CMD_COL_HIGH;
                end
                if (kp1 >= KW'(ofrs_pkg::PCMD_LEN) + KW'(prefix))
                begin
                    seq_phase = ofrs_pkg::PH_DATA;
                    seq_bcnt  = '0;
                end
            end
            default:
            begin
                // one data transaction over all pages for windowed + serial
                seq_word.word.cmd   = 1'b0;
                seq_word.word.start = (bcnt_reg == '0)
                                      && !(cfg.bus_kind && !cfg.panel_kind
                                           && (page_reg != '0));
                if (is_pre)
                begin
                    seq_word.word.data = ofrs_pkg::CTRL_DATA;
                end
                else
                begin
                    seq_word.from_ram = in_range;
                end
                if (kp1 >= KW'(ofrs_pkg::PANEL_WIDTH) + KW'(prefix))
                begin
                    seq_bcnt = '0;
                    if (page_last)
                    begin
                        seq_word.word.last = 1'b1;
                        seq_active         = 1'b0;
                        seq_phase          = ofrs_pkg::PH_WINDOW;
                        seq_page           = '0;
                    end
                    else
                    begin
                        seq_page  = page_reg + 1'b1;
                        seq_phase = cfg.panel_kind ? ofrs_pkg::PH_PAGECMD
                                                   : ofrs_pkg::PH_DATA;
                    end
                end
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ofrs_pkg::BS_INIT,
            ofrs_pkg::BS_SWEEP:
            begin
                if (sweep_done)
                begin
                    state_next = ofrs_pkg::BS_RUN;
                end
            end
            ofrs_pkg::BS_RUN:
            begin
                if (q_valid)
                begin
                    unique case (q_item.op)
                        ofrs_pkg::OP_CLEAR:
                        begin
                            state_next = ofrs_pkg::BS_SWEEP;
                        end
                        ofrs_pkg::OP_PULL:
                        begin
                            if (active_reg && out_free)
                            begin
                                state_next = ofrs_pkg::BS_LOAD;
                            end
                        end
                        ofrs_pkg::OP_WRITE,
                        ofrs_pkg::OP_START:
                        begin
                            state_next = ofrs_pkg::BS_RUN;
                        end
                    endcase
                end
            end
            ofrs_pkg::BS_LOAD:
            begin
                state_next = ofrs_pkg::BS_RUN;
            end
        endcase
    end

    always_comb
    begin
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = q_item.addr;
        ram_wdata      = q_item.data;
        sweep_next     = sweep_reg;
        active_next    = active_reg;
        phase_next     = phase_reg;
        page_next      = page_reg;
        bcnt_next      = bcnt_reg;
        pend_next      = pend_reg;
        out_word_next  = out_word_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        unique case (state_reg)
            ofrs_pkg::BS_INIT,
            ofrs_pkg::BS_SWEEP:
            begin
                ram_we     = 1'b1;
                ram_waddr  = sweep_reg;
                ram_wdata  = ofrs_pkg::FILL_BYTE;
                sweep_next = sweep_done ? '0 : sweep_reg + 1'b1;
            end
            ofrs_pkg::BS_RUN:
            begin
                if (q_valid)
                begin
                    unique case (q_item.op)
                        ofrs_pkg::OP_WRITE:
                        begin
                            ram_we = 1'b1;
                            q_pop  = 1'b1;
                        end
                        ofrs_pkg::OP_CLEAR:
                        begin
                            q_pop = 1'b1;
                        end
                        ofrs_pkg::OP_START:
                        begin
                            q_pop       = 1'b1;
                            active_next = 1'b1;
                            phase_next  = cfg.panel_kind ? ofrs_pkg::PH_PAGECMD
                                                         : ofrs_pkg::PH_WINDOW;
                            page_next   = '0;
                            bcnt_next   = '0;
                        end
                        ofrs_pkg::OP_PULL:
                        begin
                            if (!active_reg)
                            begin
                                q_pop = 1'b1;
                            end
                            else if (out_free)
                            begin
                                q_pop       = 1'b1;
                                pend_next   = seq_word;
                                active_next = seq_active;
                                phase_next  = seq_phase;
                                page_next   = seq_page;
                                bcnt_next   = seq_bcnt;
                            end
                        end
                    endcase
                end
            end
            ofrs_pkg::BS_LOAD:
            begin
                out_valid_next = 1'b1;
                out_word_next  = pend_reg.word;
                if (pend_reg.from_ram)
                begin
                    out_word_next.data = ram_rdata;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ofrs_pkg::BS_INIT;
            active_reg    <= 1'b0;
            phase_reg     <= ofrs_pkg::PH_WINDOW;
            page_reg      <= '0;
            bcnt_reg      <= '0;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            phase_reg     <= phase_next;
            page_reg      <= page_next;
            bcnt_reg      <= bcnt_next;
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        out_word_reg <= out_word_next;
    end

    assign rsp_valid  = out_valid_reg;
    assign out_byte   = out_word_reg.data;
    assign is_command = out_word_reg.cmd;
    assign txn_start  = out_word_reg.start;
    assign last_byte  = out_word_reg.last;

    `OFRS_ASSERT_IMP(a_load_slot_free, state_reg == ofrs_pkg::BS_LOAD, !out_valid_reg)
    `OFRS_ASSERT_IMP(a_init_no_pop, state_reg == ofrs_pkg::BS_INIT, !q_pop)
    `OFRS_ASSERT_IMP(a_last_ends_refresh, (state_reg == ofrs_pkg::BS_LOAD) && pend_reg.word.last, !active_reg)
    `OFRS_ASSERT_NXT(a_pull_loads, (state_reg == ofrs_pkg::BS_RUN) && q_pop && active_reg && (q_item.op == ofrs_pkg::OP_PULL), state_reg == ofrs_pkg::BS_LOAD)

endmodule

/* sv/oled_frame_refresh_sequencer.sv */
// Top level: APB register block, front end, request queue and sequencer back end
// A pull word is registered in the request queue, then in pend_reg, then in out_word_reg, which drives rsp_valid.
// Pulls pass through states RUN and LOAD (store read port, registered read), so no new pull is taken
// while one loads; writes and starts retire in RUN, a clear sweeps one store byte per cycle.
// Reset: asynchronous, active low; after release all STORE_BYTES bytes of the store are zeroed
// (1024), with req_stall high; APB writes are taken throughout.
module oled_frame_refresh_sequencer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ofrs_pkg::PADDR_W-1:0]         paddr,
    input  logic [ofrs_pkg::PDATA_W-1:0]         pwdata,
    output logic [ofrs_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready,
    input  logic                                 req_valid,
    output logic                                 req_stall,
    input  logic [ofrs_pkg::REQ_W-1:0]           req_type,
    input  logic [ofrs_pkg::STORE_INDEX_W-1:0]   store_index,
    input  logic [ofrs_pkg::BYTE_W-1:0]          store_data,
    output logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    output logic [ofrs_pkg::BYTE_W-1:0]          out_byte,
    output logic                                 is_command,
    output logic                                 txn_start,
    output logic                                 last_byte
);

    ofrs_pkg::cfg_t                  cfg_reg;
    ofrs_pkg::cfg_t                  cfg_next;
    logic [ofrs_pkg::REG_IDX_W-1:0]  reg_idx;
    logic                            wr_en;
    logic                            q_full;
    logic                            q_push;
    ofrs_pkg::q_item_t               q_in;
    logic                            q_valid;
    ofrs_pkg::q_item_t               q_out;
    logic                            q_pop;
    logic                            init_busy;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ofrs_pkg::REG_IDX_W+1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                ofrs_pkg::REG_BUS_KIND:   cfg_next.bus_kind   = pwdata[0];
                ofrs_pkg::REG_PANEL_KIND: cfg_next.panel_kind = pwdata[0];
                ofrs_pkg::REG_TALL_PANEL: cfg_next.tall_panel = pwdata[0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            ofrs_pkg::REG_BUS_KIND:   prdata = ofrs_pkg::PDATA_W'(cfg_reg.bus_kind);
            ofrs_pkg::REG_PANEL_KIND: prdata = ofrs_pkg::PDATA_W'(cfg_reg.panel_kind);
            ofrs_pkg::REG_TALL_PANEL: prdata = ofrs_pkg::PDATA_W'(cfg_reg.tall_panel);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bus_kind   <= 1'b0;
            cfg_reg.panel_kind <= 1'b0;
            cfg_reg.tall_panel <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ofrs_front u_front (
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_type    (req_type),
        .store_index (store_index),
        .store_data  (store_data),
        .q_full      (q_full),
        .init_busy   (init_busy),
        .push        (q_push),
        .item        (q_in)
    );

    ofrs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .item_in  (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .item_out (q_out)
    );

    ofrs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_item     (q_out),
        .q_pop      (q_pop),
        .init_busy  (init_busy),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .out_byte   (out_byte),
        .is_command (is_command),
        .txn_start  (txn_start),
        .last_byte  (last_byte)
    );

endmodule

/* tb/sv/tb.sv */
// Testbench for the OLED frame refresh sequencer: directed table plus random refresh traffic
`timescale 1ns / 1ps

module tb;
    import ofrs_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int IDLE_PAUSE     = STORE_BYTES + 64;

    typedef struct packed {
        op_t                      op;
        logic [STORE_INDEX_W-1:0] idx;
        logic [BYTE_W-1:0]        data;
        logic                     typed;
        out_word_t                w;
    } stim_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [PADDR_W-1:0]       paddr;
    logic [PDATA_W-1:0]       pwdata;
    logic [PDATA_W-1:0]       prdata;
    logic                     pready;
    logic                     req_valid;
    logic                     req_stall;
    logic [REQ_W-1:0]         req_type;
    logic [STORE_INDEX_W-1:0] store_index;
    logic [BYTE_W-1:0]        store_data;
    logic                     rsp_valid;
    logic                     rsp_stall;
    logic [BYTE_W-1:0]        out_byte;
    logic                     is_command;
    logic                     txn_start;
    logic                     last_byte;

    // predictor state
    logic [BYTE_W-1:0]        store_img [STORE_BYTES];
    logic                     seq_active;
    phase_t                   seq_ph;
    logic [2:0]               seq_page;
    logic [10:0]              seq_count;
    cfg_t                     live_cfg;

    out_word_t                pending_words [$];
    out_word_t                head_w;
    int                       mismatch_count;
    int                       quiet_cycles;
    bit                       calm;
    bit                       hold_req;

    // pulls carry don't-care index/data on purpose
    stim_row_t dir_rows [22] = '{
        {OP_PULL,  10'h3FF, 8'hFF, 1'b0, {8'h00, 3'b000}},
        {OP_WRITE, 10'h000, 8'hFF, 1'b0, {8'h00, 3'b000}},
        {OP_WRITE, 10'h3FF, 8'h80, 1'b0, {8'h00, 3'b000}},
        {OP_WRITE, 10'h001, 8'h01, 1'b0, {8'h00, 3'b000}},
        {OP_START, 10'h000, 8'h00, 1'b0, {8'h00, 3'b000}},
        {OP_PULL,  10'h000, 8'h00, 1'b1, {8'h00, 3'b110}},
        {OP_PULL,  10'h155, 8'h55, 1'b1, {8'h21, 3'b100}},
        {OP_PULL,  10'h2AA, 8'hAA, 1'b1, {8'h00, 3'b100}},
        {OP_PULL,  10'h000, 8'h00, 1'b1, {8'h7F, 3'b100}},
        {OP_PULL,  10'h000, 8'h00, 1'b1, {8'h22, 3'b100}},
        {OP_PULL,  10'h000, 8'h00, 1'b1, {8'h00, 3'b100}},
        {OP_PULL,  10'h000, 8'h00, 1'b1, {8'h07, 3'b100}},
        {OP_PULL,  10'h000, 8'h00, 1'b1, {8'h40, 3'b010}},
        {OP_PULL,  10'h000, 8'h00, 1'b1, {8'hFF, 3'b000}},
        {OP_WRITE, 10'h002, 8'h5A, 1'b0, {8'h00, 3'b000}},
        {OP_CLEAR, 10'h000, 8'h00, 1'b0, {8'h00, 3'b000}},
        {OP_PULL,  10'h000, 8'h00, 1'b1, {8'h00, 3'b000}},
        {OP_WRITE, 10'h002, 8'hA5, 1'b0, {8'h00, 3'b000}},
        {OP_PULL,  10'h000, 8'h00, 1'b1, {8'hA5, 3'b000}},
        {OP_START, 10'h000, 8'h00, 1'b0, {8'h00, 3'b000}},
        {OP_PULL,  10'h000, 8'h00, 1'b1, {8'h00, 3'b110}},
        {OP_PULL,  10'h000, 8'h00, 1'b1, {8'h21, 3'b100}}
    };

    oled_frame_refresh_sequencer DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_type    (req_type),
        .store_index (store_index),
        .store_data  (store_data),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .out_byte    (out_byte),
        .is_command  (is_command),
        .txn_start   (txn_start),
        .last_byte   (last_byte)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic bit sequence_step(input op_t op, input logic [STORE_INDEX_W-1:0] idx,
                                         input logic [BYTE_W-1:0] data, output out_word_t w);
        int unsigned pages;
        int unsigned pre;
        int unsigned k;
        int unsigned len;
        int unsigned i;
        int unsigned a;
        pages = live_cfg.tall_panel ? 8 : 4;
        pre = live_cfg.bus_kind ? 0 : 1;
        k = seq_count;
        w = '0;
        case (op)
            OP_WRITE:
            begin
                store_img[idx] = data;
                return 1'b0;
            end
            OP_CLEAR:
            begin
                foreach (store_img[j])
                    store_img[j] = 8'h00;
                return 1'b0;
            end
            OP_START:
            begin
                seq_active = 1'b1;
                seq_ph = live_cfg.panel_kind ? PH_PAGECMD : PH_WINDOW;
                seq_page = '0;
                seq_count = '0;
                return 1'b0;
            end
            default: ;
        endcase
        if (!seq_active)
            return 1'b0;

        if (seq_ph == PH_WINDOW)
        begin
            len = pre + WIN_LEN;
            w.cmd = 1'b1;
            w.start = (k == 0);
            if (pre != 0 && k == 0)
                w.data = CTRL_CMD;
            else
            begin
                i = k - pre;
                case (i)
                    0: w.data = CMD_COL_WINDOW;
                    2: w.data = PANEL_WIDTH - 1;
                    3: w.data = CMD_PAGE_WINDOW;
                    5: w.data = pages - 1;
                    default: w.data = FILL_BYTE;
                endcase
            end
            if (k + 1 >= len)
            begin
                seq_ph = PH_DATA;
                seq_page = '0;
                seq_count = '0;
            end
            else
                seq_count = k + 1;
        end
        else if (seq_ph == PH_PAGECMD)
        begin
            len = pre + PCMD_LEN;
            w.cmd = 1'b1;
            w.start = (k == 0);
            if (pre != 0 && k == 0)
                w.data = CTRL_CMD;
            else
            begin
                i = k - pre;
                case (i)
                    0: w.data = CMD_PAGE_BASE + seq_page;
                    1: w.data = CMD_COL_LOW;
                    2: w.data = CMD_COL_HIGH;
                    default: w.data = FILL_BYTE;
                endcase
            end
            if (k + 1 >= len)
            begin
                seq_ph = PH_DATA;
                seq_count = '0;
            end
            else
                seq_count = k + 1;
        end
        else
        begin
            len = pre + PANEL_WIDTH;
            w.cmd = 1'b0;
            w.start = (k == 0) &&
                      !(live_cfg.bus_kind && !live_cfg.panel_kind && seq_page != 0);
            if (pre != 0 && k == 0)
                w.data = CTRL_DATA;
            else
            begin
                a = seq_page * PANEL_WIDTH + k - pre;
                w.data = (a < STORE_BYTES) ? store_img[a] : FILL_BYTE;
            end
            if (k + 1 >= len)
            begin
                seq_count = '0;
                if (seq_page + 1 >= pages)
                begin
                    w.last = 1'b1;
                    seq_active = 1'b0;
                    seq_ph = PH_WINDOW;
                    seq_page = '0;
                end
                else
                begin
                    seq_page = seq_page + 1;
                    seq_ph = live_cfg.panel_kind ? PH_PAGECMD : PH_DATA;
                end
            end
            else
                seq_count = k + 1;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < 40)
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    task automatic send_word(input op_t op, input logic [STORE_INDEX_W-1:0] idx,
                             input logic [BYTE_W-1:0] data, input logic typed,
                             input out_word_t typed_w);
        out_word_t w;
        bit got;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        req_valid   <= 1'b1;
        req_type    <= op;
        store_index <= idx;
        store_data  <= data;
        do @(posedge clk); while (req_stall);
        got = sequence_step(op, idx, data, w);
        if (got)
            pending_words.push_back(typed ? typed_w : w);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(PDATA_W-1){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_BUS_KIND:   live_cfg.bus_kind = value;
            REG_PANEL_KIND: live_cfg.panel_kind = value;
            REG_TALL_PANEL: live_cfg.tall_panel = value;
            default: ;
        endcase
    endtask

    // block idle: nothing owed, then room for a clear still sweeping
    task automatic settle();
        req_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
        repeat (IDLE_PAUSE) @(posedge clk);
    endtask

    task automatic random_phase(input int n_items, input int restart_pm);
        int unsigned r;
        repeat (n_items)
        begin
            r = $urandom_range(0, 999);
            if (!seq_active)
            begin
                if (r < 150)
                    send_word(OP_PULL, $urandom_range(0, 1023), $urandom_range(0, 255),
                              1'b0, '0);
                else if (r < 400)
                    send_word(OP_WRITE, $urandom_range(0, 1023), $urandom_range(0, 255),
                              1'b0, '0);
                else if (r < 405)
                    send_word(OP_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 255),
                              1'b0, '0);
                else
                    send_word(OP_START, $urandom_range(0, 1023), $urandom_range(0, 255),
                              1'b0, '0);
            end
            else if (r < restart_pm)
                send_word(OP_START, $urandom_range(0, 1023), $urandom_range(0, 255), 1'b0, '0);
            else if (r < 860)
                send_word(OP_PULL, $urandom_range(0, 1023), $urandom_range(0, 255), 1'b0, '0);
            else if (r < 997)
                send_word(OP_WRITE, $urandom_range(0, 1023), $urandom_range(0, 255), 1'b0, '0);
            else
                send_word(OP_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 255), 1'b0, '0);
        end
    endtask

    // receiver
    initial
    begin
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                rsp_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            else if ($urandom_range(0, 15) == 0)
                repeat ($urandom_range(20, 80)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_words.size() == 0)
                report_mismatch("unexpected word", out_byte, 0);
            else
            begin
                head_w = pending_words.pop_front();
                if (out_byte !== head_w.data)
                    report_mismatch("out_byte", out_byte, head_w.data);
                if (is_command !== head_w.cmd)
                    report_mismatch("is_command", is_command, head_w.cmd);
                if (txn_start !== head_w.start)
                    report_mismatch("txn_start", txn_start, head_w.start);
                if (last_byte !== head_w.last)
                    report_mismatch("last_byte", last_byte, head_w.last);
            end
        end
    end

    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n       <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        req_valid   <= 1'b0;
        req_type    <= OP_WRITE;
        store_index <= '0;
        store_data  <= '0;
        mismatch_count = 0;
        calm = 1'b0;
        hold_req = 1'b0;
        foreach (store_img[j])
            store_img[j] = 8'h00;
        seq_active = 1'b0;
        seq_ph = PH_WINDOW;
        seq_page = '0;
        seq_count = '0;
        live_cfg = '0;
        live_cfg.tall_panel = 1'b1;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_word(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].data,
                      dir_rows[i].typed, dir_rows[i].w);
        settle();

        // tall windowed refresh on the two-wire bus, stopped before its final word
        send_word(OP_START, 10'h000, 8'h00, 1'b0, '0);
        while (!(seq_active && seq_ph == PH_DATA && seq_page == 7 && seq_count == PANEL_WIDTH))
        begin
            if ($urandom_range(0, 999) < 940)
                send_word(OP_PULL, $urandom_range(0, 1023), $urandom_range(0, 255), 1'b0, '0);
            else if ($urandom_range(0, 99) < 95)
                send_word(OP_WRITE, $urandom_range(0, 1023), $urandom_range(0, 255), 1'b0, '0);
            else
                send_word(OP_CLEAR, 10'h000, 8'h00, 1'b0, '0);
        end
        settle();

        // bus switch drops the control byte: final word reads past the store end
        write_reg(REG_BUS_KIND, 1'b1);
        send_word(OP_PULL, 10'h000, 8'h00, 1'b1, {8'h00, 3'b001});
        random_phase(150, 5);
        settle();

        write_reg(REG_TALL_PANEL, 1'b0);
        hold_req = 1'b1;
        random_phase(700, 0);
        settle();

        write_reg(REG_PANEL_KIND, 1'b1);
        random_phase(700, 0);
        settle();

        write_reg(REG_BUS_KIND, 1'b0);
        write_reg(REG_TALL_PANEL, 1'b1);
        calm = 1'b1;
        random_phase(200, 5);
        req_valid <= 1'b0;

        while (pending_words.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && pending_words.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
